[rtl/dbb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbb_pkg
// Shared widths, register map, reset values and interface types for the
// dark border bounding box unit.
// ----------------------------------------------------------------------------
package dbb_pkg;

	localparam int MAX_DIM_DEF = 4096;

	localparam int CHAN_W     = 8;
	localparam int DIM_CFG_W  = 13;
	localparam int CROP_POS_W = 12;
	localparam int CROP_LEN_W = 13;
	localparam int DATA_W     = 32;
	localparam int PADDR_W    = 4;

	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_COLOUR_MODE  = 2'd2;
	localparam logic [1:0] REG_DARK_LEVEL   = 2'd3;

	localparam logic [DIM_CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
	localparam logic [DIM_CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;
	localparam logic                 COLOUR_MODE_RST  = 1'b0;
	localparam logic [CHAN_W-1:0]    DARK_LEVEL_RST   = 8'd30;

	typedef struct packed {
		logic              colour_mode;
		logic [CHAN_W-1:0] dark_level;
	} pix_cfg_t;

	typedef struct packed {
		logic valid;
		logic content;
	} pix_t;

endpackage

[rtl/dark_border_bounding_box_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dark_border_bounding_box_unit
// Crop rectangle of the non-dark content of a raster-order frame.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on in_valid/in_stall with chan_a, chan_b, chan_c, one item
//   per pixel in raster order. One pixel is taken every cycle while the
//   result side is not blocked.
//   After the last pixel of a frame one item leaves on out_valid/out_stall
//   with crop_x, crop_y, crop_width, crop_height; an all-dark frame gives
//   0, 0, 1, 1. The result is registered: the last pixel is loaded into the
//   input register, and the result register is loaded when the box tracker
//   takes that pixel, which waits there while a held result is stalled.
//   Throughput is one pixel per cycle while no stalled result blocks a frame
//   end, set by the compare and update of the counters and box registers.
//   Frame size, colour mode and dark level sit in APB registers 4 bytes apart;
//   the user must write them between frames, unchecked; pready stays high.
//   Reset clears the counters, box and both valid flags and loads the default
//   configuration (640 x 480, gray, dark level 30); no clearing pass is needed.
//   While out_stall holds a result, pixels keep flowing until the next frame
//   end, which then waits in the input register and raises in_stall.
// ----------------------------------------------------------------------------
module dark_border_bounding_box_unit #(
	parameter int MAX_DIM = dbb_pkg::MAX_DIM_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [dbb_pkg::PADDR_W-1:0]    paddr,
	input  logic [dbb_pkg::DATA_W-1:0]     pwdata,
	output logic [dbb_pkg::DATA_W-1:0]     prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [dbb_pkg::CHAN_W-1:0]     chan_a,
	input  logic [dbb_pkg::CHAN_W-1:0]     chan_b,
	input  logic [dbb_pkg::CHAN_W-1:0]     chan_c,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [dbb_pkg::CROP_POS_W-1:0] crop_x,
	output logic [dbb_pkg::CROP_POS_W-1:0] crop_y,
	output logic [dbb_pkg::CROP_LEN_W-1:0] crop_width,
	output logic [dbb_pkg::CROP_LEN_W-1:0] crop_height
);
	import dbb_pkg::*;

	localparam int POS_W = $clog2(MAX_DIM);

	pix_cfg_t         pix_cfg;
	pix_t             pix_s1;
	logic             take;
	logic [POS_W-1:0] last_col;
	logic [POS_W-1:0] last_row;

	dbb_cfg_regs #(
		.MAX_DIM(MAX_DIM)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pix_cfg (pix_cfg),
		.last_col(last_col),
		.last_row(last_row)
	);

	dbb_pixel_stage u_pix (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.chan_a  (chan_a),
		.chan_b  (chan_b),
		.chan_c  (chan_c),
		.pix_cfg (pix_cfg),
		.take    (take),
		.pix_s1  (pix_s1)
	);

	dbb_box_track #(
		.MAX_DIM(MAX_DIM)
	) u_box (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix        (pix_s1),
		.take       (take),
		.last_col   (last_col),
		.last_row   (last_row),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.crop_x     (crop_x),
		.crop_y     (crop_y),
		.crop_width (crop_width),
		.crop_height(crop_height)
	);

endmodule

[rtl/dbb_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbb_cfg_regs
// APB register file: frame size, colour mode and dark level, with the last
// column and last row derived from the clamped frame size.
// ----------------------------------------------------------------------------
module dbb_cfg_regs #(
	parameter int MAX_DIM = dbb_pkg::MAX_DIM_DEF,
	localparam int POS_W = $clog2(MAX_DIM)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dbb_pkg::PADDR_W-1:0] paddr,
	input  logic [dbb_pkg::DATA_W-1:0]  pwdata,
	output logic [dbb_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output dbb_pkg::pix_cfg_t           pix_cfg,
	output logic [POS_W-1:0]            last_col,
	output logic [POS_W-1:0]            last_row
);
	import dbb_pkg::*;

	localparam int CW = (POS_W + 1 > DIM_CFG_W) ? POS_W + 1 : DIM_CFG_W;

	logic [DIM_CFG_W-1:0] frame_width_q;
	logic [DIM_CFG_W-1:0] frame_height_q;
	logic                 colour_mode_q;
	logic [CHAN_W-1:0]    dark_level_q;
	logic                 wr_en;
	logic [1:0]           reg_idx;
	logic [CW-1:0]        fw_ext;
	logic [CW-1:0]        fh_ext;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			colour_mode_q  <= COLOUR_MODE_RST;
			dark_level_q   <= DARK_LEVEL_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[DIM_CFG_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[DIM_CFG_W-1:0];
				REG_COLOUR_MODE:  colour_mode_q  <= pwdata[0];
				REG_DARK_LEVEL:   dark_level_q   <= pwdata[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_q);
			REG_COLOUR_MODE:  prdata = DATA_W'(colour_mode_q);
			REG_DARK_LEVEL:   prdata = DATA_W'(dark_level_q);
			default:          prdata = '0;
		endcase
	end

	assign fw_ext = CW'(frame_width_q);
	assign fh_ext = CW'(frame_height_q);

	always_comb begin
		priority if (fw_ext == '0)
			last_col = '0;
		else if (fw_ext > CW'(MAX_DIM))
			last_col = POS_W'(MAX_DIM - 1);
		else
			last_col = POS_W'(fw_ext - CW'(1));
	end

	always_comb begin
		priority if (fh_ext == '0)
			last_row = '0;
		else if (fh_ext > CW'(MAX_DIM))
			last_row = POS_W'(MAX_DIM - 1);
		else
			last_row = POS_W'(fh_ext - CW'(1));
	end

	assign pix_cfg.colour_mode = colour_mode_q;
	assign pix_cfg.dark_level  = dark_level_q;

endmodule

[rtl/dbb_pixel_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbb_pixel_stage
// Input register: classify each pixel as content or dark border and hold
// the flag until the box tracker takes it.
// ----------------------------------------------------------------------------
module dbb_pixel_stage (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [dbb_pkg::CHAN_W-1:0] chan_a,
	input  logic [dbb_pkg::CHAN_W-1:0] chan_b,
	input  logic [dbb_pkg::CHAN_W-1:0] chan_c,
	input  dbb_pkg::pix_cfg_t          pix_cfg,
	input  logic                       take,
	output dbb_pkg::pix_t              pix_s1
);
	import dbb_pkg::*;

	logic valid_s1;
	logic content_s1;
	logic content;
	logic load;

	always_comb begin
		if (pix_cfg.colour_mode)
			content = (chan_a > pix_cfg.dark_level) || (chan_b > pix_cfg.dark_level) ||
				(chan_c > pix_cfg.dark_level);
		else
			content = (chan_a >= pix_cfg.dark_level);
	end

	assign in_stall = valid_s1 & ~take;
	assign load     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= load | (valid_s1 & ~take);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			content_s1 <= content;
		end
	end

	assign pix_s1.valid   = valid_s1;
	assign pix_s1.content = content_s1;

endmodule

[rtl/dbb_box_track.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbb_box_track
// Raster position counters, running content box and the result register
// that holds the crop rectangle at the end of each frame.
// ----------------------------------------------------------------------------
module dbb_box_track #(
	parameter int MAX_DIM = dbb_pkg::MAX_DIM_DEF,
	localparam int POS_W = $clog2(MAX_DIM)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dbb_pkg::pix_t                  pix,
	output logic                           take,
	input  logic [POS_W-1:0]               last_col,
	input  logic [POS_W-1:0]               last_row,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [dbb_pkg::CROP_POS_W-1:0] crop_x,
	output logic [dbb_pkg::CROP_POS_W-1:0] crop_y,
	output logic [dbb_pkg::CROP_LEN_W-1:0] crop_width,
	output logic [dbb_pkg::CROP_LEN_W-1:0] crop_height
);
	import dbb_pkg::*;

	logic [POS_W-1:0] col_q, row_q;
	logic [POS_W-1:0] top_q, bottom_q, left_q, right_q;
	logic             seen_q;
	logic             out_valid_q;

	logic [POS_W-1:0] top_nx, bottom_nx, left_nx, right_nx;
	logic             seen_nx;
	logic             row_end, frame_end, out_free;
	logic [POS_W:0]   w_full, h_full;

	always_comb begin
		top_nx    = top_q;
		bottom_nx = bottom_q;
		left_nx   = left_q;
		right_nx  = right_q;
		seen_nx   = seen_q;
		if (pix.content) begin
			seen_nx = 1'b1;
			if (!seen_q) begin
				top_nx    = row_q;
				bottom_nx = row_q;
				left_nx   = col_q;
				right_nx  = col_q;
			end else begin
				if (row_q < top_q)    top_nx    = row_q;
				if (row_q > bottom_q) bottom_nx = row_q;
				if (col_q < left_q)   left_nx   = col_q;
				if (col_q > right_q)  right_nx  = col_q;
			end
		end
	end

	assign row_end   = col_q >= last_col;
	assign frame_end = row_end && (row_q >= last_row);
	assign out_free  = ~out_valid_q | ~out_stall;
	assign take      = pix.valid & (~frame_end | out_free);

	assign w_full = {1'b0, right_nx} - {1'b0, left_nx} + (POS_W + 1)'(1);
	assign h_full = {1'b0, bottom_nx} - {1'b0, top_nx} + (POS_W + 1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			top_q    <= '0;
			bottom_q <= '0;
			left_q   <= '0;
			right_q  <= '0;
			seen_q   <= 1'b0;
		end else if (take) begin
			if (frame_end) begin
				col_q    <= '0;
				row_q    <= '0;
				top_q    <= '0;
				bottom_q <= '0;
				left_q   <= '0;
				right_q  <= '0;
				seen_q   <= 1'b0;
			end else begin
				top_q    <= top_nx;
				bottom_q <= bottom_nx;
				left_q   <= left_nx;
				right_q  <= right_nx;
				seen_q   <= seen_nx;
				if (row_end) begin
					col_q <= '0;
					row_q <= row_q + POS_W'(1);
				end else begin
					col_q <= col_q + POS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && frame_end) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && frame_end) begin
			if (seen_nx) begin
				crop_x      <= CROP_POS_W'(left_nx);
				crop_y      <= CROP_POS_W'(top_nx);
				crop_width  <= CROP_LEN_W'(w_full);
				crop_height <= CROP_LEN_W'(h_full);
			end else begin
				crop_x      <= '0;
				crop_y      <= '0;
				crop_width  <= CROP_LEN_W'(1);
				crop_height <= CROP_LEN_W'(1);
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |-> (left_q <= right_q) && (top_q <= bottom_q))
		else $error("box corners out of order");

	a_box_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_q |-> (top_q == '0) && (bottom_q == '0) && (left_q == '0) && (right_q == '0))
		else $error("box holds data with no content seen");

	a_frame_result: assert property (@(posedge clk) disable iff (!arst_n)
		take && frame_end |=> out_valid_q && (col_q == '0) && (row_q == '0) && !seen_q)
		else $error("frame end did not post a result and restart");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !(take && frame_end))
		else $error("result overwritten while stalled");
`endif

endmodule
